// ===== sv/one_tap_phase_equalizer_defines.svh =====
// Assertion macros for the one-tap phase equalizer.
// Included by the top level only; depends on nothing else.
`ifndef ONE_TAP_PHASE_EQUALIZER_DEFINES_SVH
`define ONE_TAP_PHASE_EQUALIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ote_pkg.sv =====
// Shared types and fixed widths of the one-tap phase equalizer.
// Used by every module of the block; depends on nothing.
package ote_pkg;

    // Width of the square root operand and of its running result.
    localparam int XW = 64;
    // Width of the channel magnitude after the square root.
    localparam int MW = 32;
    // Total bits of sample plus extra magnitude fraction bits.
    localparam int FULL_BITS = 32;

    // Sideband control that travels with every pipeline stage.
    typedef struct packed {
        logic valid;
        logic last;
        logic zero;
    } ote_ctl_t;

endpackage

// ===== sv/ote_front.sv =====
// Front end of the equalizer: products, sums and magnitude operand.
// Depends on ote_pkg.
module ote_front #(
    parameter int W = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  ote_pkg::ote_ctl_t               in_ctl,
    input  logic                            bpsk,
    input  logic signed [W-1:0]             sr,
    input  logic signed [W-1:0]             si,
    input  logic signed [W-1:0]             cr,
    input  logic signed [W-1:0]             ci,
    output ote_pkg::ote_ctl_t               out_ctl,
    output logic [2*W:0]                    nmag,
    output logic                            nneg,
    output logic [2*W:0]                    imag,
    output logic                            ineg,
    output logic [ote_pkg::XW-1:0]          x
);
    import ote_pkg::*;

    localparam int F = FULL_BITS - W;

    ote_ctl_t              a_ctl_reg, a_ctl_next;
    logic                  a_bpsk_reg;
    logic signed [W-1:0]   a_sr_reg;
    logic signed [2*W-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_cc_reg, p_dd_reg;

    ote_ctl_t              b_ctl_reg;
    logic [2*W:0]          b_nmag_reg, b_imag_reg, b_nmag_next, b_imag_next;
    logic                  b_nneg_reg, b_ineg_reg, b_nneg_next, b_ineg_next;
    logic [XW-1:0]         b_x_reg, b_x_next;

    logic signed [2*W:0]   nr, ni;
    logic [2*W-1:0]        m2;

    // The zero-channel flag is only meaningful in equalize mode.
    always_comb
    begin
        a_ctl_next      = in_ctl;
        a_ctl_next.zero = !bpsk && (cr == '0) && (ci == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
        end
        else if (en)
        begin
            a_ctl_reg <= a_ctl_next;
            b_ctl_reg <= a_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_bpsk_reg <= bpsk;
            a_sr_reg   <= sr;
            p_rr_reg   <= sr * cr;
            p_ii_reg   <= si * ci;
            p_ir_reg   <= si * cr;
            p_ri_reg   <= sr * ci;
            p_cc_reg   <= cr * cr;
            p_dd_reg   <= ci * ci;
        end
    end

    // In BPSK mode the divider is fed |sr| over a unit magnitude, which
    // returns the real part unchanged and a zero imaginary part.
    always_comb
    begin
        nr = {p_rr_reg[2*W-1], p_rr_reg} + {p_ii_reg[2*W-1], p_ii_reg};
        ni = {p_ir_reg[2*W-1], p_ir_reg} - {p_ri_reg[2*W-1], p_ri_reg};
        m2 = p_cc_reg[2*W-1:0] + p_dd_reg[2*W-1:0];
        if (a_bpsk_reg)
        begin
            nr = (2*W+1)'(a_sr_reg);
            ni = '0;
            m2 = (2*W)'(1);
        end
        b_nneg_next = nr[2*W];
        b_ineg_next = ni[2*W];
        b_nmag_next = nr[2*W] ? (2*W+1)'(-nr) : (2*W+1)'(nr);
        b_imag_next = ni[2*W] ? (2*W+1)'(-ni) : (2*W+1)'(ni);
        b_x_next    = XW'(m2) << (2 * F);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_nmag_reg <= b_nmag_next;
            b_imag_reg <= b_imag_next;
            b_nneg_reg <= b_nneg_next;
            b_ineg_reg <= b_ineg_next;
            b_x_reg    <= b_x_next;
        end
    end

    assign out_ctl = b_ctl_reg;
    assign nmag    = b_nmag_reg;
    assign nneg    = b_nneg_reg;
    assign imag    = b_imag_reg;
    assign ineg    = b_ineg_reg;
    assign x       = b_x_reg;

endmodule

// ===== sv/ote_sqrt_step.sv =====
// One stage of the pipelined integer square root (one result bit).
// Depends on ote_pkg.
module ote_sqrt_step #(
    parameter int STEP = 0,
    parameter int PW   = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  ote_pkg::ote_ctl_t      in_ctl,
    input  logic [ote_pkg::XW-1:0] in_x,
    input  logic [ote_pkg::XW-1:0] in_res,
    input  logic [PW-1:0]          in_pay,
    output ote_pkg::ote_ctl_t      out_ctl,
    output logic [ote_pkg::XW-1:0] out_x,
    output logic [ote_pkg::XW-1:0] out_res,
    output logic [PW-1:0]          out_pay
);
    import ote_pkg::*;

    localparam logic [XW-1:0] BIT = XW'(1) << (2 * STEP);

    ote_ctl_t      ctl_reg;
    logic [XW-1:0] x_reg, x_next, res_reg, res_next, trial;
    logic [PW-1:0] pay_reg;

    always_comb
    begin
        trial = in_res + BIT;
        if (in_x >= trial)
        begin
            x_next   = in_x - trial;
            res_next = (in_res >> 1) + BIT;
        end
        else
        begin
            x_next   = in_x;
            res_next = in_res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= in_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            res_reg <= res_next;
            pay_reg <= in_pay;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_x   = x_reg;
    assign out_res = res_reg;
    assign out_pay = pay_reg;

endmodule

// ===== sv/ote_div_step.sv =====
// One stage of the restoring divider for both output lanes (one quotient bit).
// Depends on ote_pkg.
module ote_div_step #(
    parameter int STEP = 0,
    parameter int DW   = 50,
    parameter int QW   = 17,
    parameter int PW   = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  ote_pkg::ote_ctl_t      in_ctl,
    input  logic [ote_pkg::MW-1:0] in_m,
    input  logic [DW-1:0]          in_r_re,
    input  logic [DW-1:0]          in_r_im,
    input  logic [QW-1:0]          in_q_re,
    input  logic [QW-1:0]          in_q_im,
    input  logic [PW-1:0]          in_pay,
    output ote_pkg::ote_ctl_t      out_ctl,
    output logic [ote_pkg::MW-1:0] out_m,
    output logic [DW-1:0]          out_r_re,
    output logic [DW-1:0]          out_r_im,
    output logic [QW-1:0]          out_q_re,
    output logic [QW-1:0]          out_q_im,
    output logic [PW-1:0]          out_pay
);
    import ote_pkg::*;

    ote_ctl_t      ctl_reg;
    logic [MW-1:0] m_reg;
    logic [DW-1:0] r_re_reg, r_im_reg, r_re_next, r_im_next, trial;
    logic [QW-1:0] q_re_reg, q_im_reg, q_re_next, q_im_next;
    logic [PW-1:0] pay_reg;

    always_comb
    begin
        trial     = DW'(in_m) << STEP;
        r_re_next = in_r_re;
        r_im_next = in_r_im;
        q_re_next = in_q_re;
        q_im_next = in_q_im;
        if (in_r_re >= trial)
        begin
            r_re_next       = in_r_re - trial;
            q_re_next[STEP] = 1'b1;
        end
        if (in_r_im >= trial)
        begin
            r_im_next       = in_r_im - trial;
            q_im_next[STEP] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= in_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= in_m;
            r_re_reg <= r_re_next;
            r_im_reg <= r_im_next;
            q_re_reg <= q_re_next;
            q_im_reg <= q_im_next;
            pay_reg  <= in_pay;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_m    = m_reg;
    assign out_r_re = r_re_reg;
    assign out_r_im = r_im_reg;
    assign out_q_re = q_re_reg;
    assign out_q_im = q_im_reg;
    assign out_pay  = pay_reg;

endmodule

// ===== sv/one_tap_phase_equalizer.sv =====
// Throughput: one sample per clock while the output is not stalled; the 32-stage
// square root and the SAMPLE_WIDTH+1 stage divider each resolve one bit per stage.
// A stall on the output freezes every stage together; nothing is dropped.
// Reset (rst_n, asynchronous, active low) empties the pipeline and clears bpsk_mode.
// Depends on ote_pkg, ote_front, ote_sqrt_step, ote_div_step and the defines header.
`include "one_tap_phase_equalizer_defines.svh"

module one_tap_phase_equalizer #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // Configuration write channel: bit 0 is bpsk_mode.
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [0:0]                                 cfg_data,
    // Input stream.
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata, lowest bits first: sample_real, sample_imag, channel_real, channel_imag.
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    input  logic                                       s_axis_tlast,
    // Output stream.
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // tdata, lowest bits first: equalized_real, equalized_imag.
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    // tuser: zero_channel.
    output logic [0:0]                                 m_axis_tuser,
    output logic                                       m_axis_tlast
);
    import ote_pkg::*;

    localparam int W      = SAMPLE_WIDTH;
    localparam int F      = FULL_BITS - W;
    localparam int OUT_TW = ((2*W+7)/8)*8;
    localparam int MAGW   = 2*W + 1;
    // Sign and magnitude of both numerators ride along the square root.
    localparam int SPW    = 2 * (MAGW + 1);
    localparam int SQ_N   = MW;
    // Dividend: magnitude shifted by F plus half the divisor, with headroom.
    localparam int DW     = W + 34;
    localparam int QW     = W + 1;
    // Sign and overflow of both lanes ride along the divider.
    localparam int DPW    = 4;
    localparam int DIV_N  = W + 1;

    // The whole pipeline advances together whenever the output slot can move.
    logic adv;
    logic bpsk_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bpsk_mode_reg <= 1'b0;
        else if (cfg_valid)
            bpsk_mode_reg <= cfg_data[0];
    end

    // ---------------------------------------------------------------------
    // Front end: four cross products and the squared magnitude.
    // ---------------------------------------------------------------------
    ote_ctl_t      in_ctl, fr_ctl;
    logic [MAGW-1:0] fr_nmag, fr_imag;
    logic          fr_nneg, fr_ineg;
    logic [XW-1:0] fr_x;

    always_comb
    begin
        in_ctl.valid = s_axis_tvalid;
        in_ctl.last  = s_axis_tlast;
        in_ctl.zero  = 1'b0;
    end

    ote_front #(.W(W)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_ctl  (in_ctl),
        .bpsk    (bpsk_mode_reg),
        .sr      (s_axis_tdata[W-1:0]),
        .si      (s_axis_tdata[2*W-1:W]),
        .cr      (s_axis_tdata[3*W-1:2*W]),
        .ci      (s_axis_tdata[4*W-1:3*W]),
        .out_ctl (fr_ctl),
        .nmag    (fr_nmag),
        .nneg    (fr_nneg),
        .imag    (fr_imag),
        .ineg    (fr_ineg),
        .x       (fr_x)
    );

    // ---------------------------------------------------------------------
    // Square root: one result bit per stage, most significant first.
    // ---------------------------------------------------------------------
    ote_ctl_t       sq_ctl [SQ_N+1];
    logic [XW-1:0]  sq_x   [SQ_N+1];
    logic [XW-1:0]  sq_res [SQ_N+1];
    logic [SPW-1:0] sq_pay [SQ_N+1];

    assign sq_ctl[0] = fr_ctl;
    assign sq_x[0]   = fr_x;
    assign sq_res[0] = '0;
    assign sq_pay[0] = {fr_ineg, fr_imag, fr_nneg, fr_nmag};

    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        ote_sqrt_step #(.STEP(SQ_N - 1 - i), .PW(SPW)) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_ctl  (sq_ctl[i]),
            .in_x    (sq_x[i]),
            .in_res  (sq_res[i]),
            .in_pay  (sq_pay[i]),
            .out_ctl (sq_ctl[i+1]),
            .out_x   (sq_x[i+1]),
            .out_res (sq_res[i+1]),
            .out_pay (sq_pay[i+1])
        );
    end

    // ---------------------------------------------------------------------
    // Divider setup: add half the divisor for rounding and flag a quotient
    // that would not fit the quotient register.
    // ---------------------------------------------------------------------
    logic [MW-1:0]   sq_m;
    logic [MAGW-1:0] sq_nmag, sq_imag;
    logic            sq_nneg, sq_ineg;
    logic [DW-1:0]   d_re, d_im, d_lim;

    ote_ctl_t      pr_ctl_reg;
    logic [MW-1:0] pr_m_reg;
    logic [DW-1:0] pr_re_reg, pr_im_reg;
    logic [DPW-1:0] pr_pay_reg;

    always_comb
    begin
        sq_m    = sq_res[SQ_N][MW-1:0];
        sq_nmag = sq_pay[SQ_N][MAGW-1:0];
        sq_nneg = sq_pay[SQ_N][MAGW];
        sq_imag = sq_pay[SQ_N][2*MAGW:MAGW+1];
        sq_ineg = sq_pay[SQ_N][2*MAGW+1];
        d_re    = (DW'(sq_nmag) << F) + DW'(sq_m >> 1);
        d_im    = (DW'(sq_imag) << F) + DW'(sq_m >> 1);
        d_lim   = DW'(sq_m) << QW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_ctl_reg <= '0;
        else if (adv)
            pr_ctl_reg <= sq_ctl[SQ_N];
    end

    // Payload bits: real sign, imaginary sign, real overflow, imaginary overflow.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_m_reg   <= sq_m;
            pr_re_reg  <= d_re;
            pr_im_reg  <= d_im;
            pr_pay_reg <= {(d_im >= d_lim), (d_re >= d_lim), sq_ineg, sq_nneg};
        end
    end

    // ---------------------------------------------------------------------
    // Divider: both lanes share the divisor, one quotient bit per stage.
    // ---------------------------------------------------------------------
    ote_ctl_t       dv_ctl  [DIV_N+1];
    logic [MW-1:0]  dv_m    [DIV_N+1];
    logic [DW-1:0]  dv_r_re [DIV_N+1];
    logic [DW-1:0]  dv_r_im [DIV_N+1];
    logic [QW-1:0]  dv_q_re [DIV_N+1];
    logic [QW-1:0]  dv_q_im [DIV_N+1];
    logic [DPW-1:0] dv_pay  [DIV_N+1];

    assign dv_ctl[0]  = pr_ctl_reg;
    assign dv_m[0]    = pr_m_reg;
    assign dv_r_re[0] = pr_re_reg;
    assign dv_r_im[0] = pr_im_reg;
    assign dv_q_re[0] = '0;
    assign dv_q_im[0] = '0;
    assign dv_pay[0]  = pr_pay_reg;

    for (genvar j = 0; j < DIV_N; j++)
    begin : g_div
        ote_div_step #(.STEP(DIV_N - 1 - j), .DW(DW), .QW(QW), .PW(DPW)) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_ctl   (dv_ctl[j]),
            .in_m     (dv_m[j]),
            .in_r_re  (dv_r_re[j]),
            .in_r_im  (dv_r_im[j]),
            .in_q_re  (dv_q_re[j]),
            .in_q_im  (dv_q_im[j]),
            .in_pay   (dv_pay[j]),
            .out_ctl  (dv_ctl[j+1]),
            .out_m    (dv_m[j+1]),
            .out_r_re (dv_r_re[j+1]),
            .out_r_im (dv_r_im[j+1]),
            .out_q_re (dv_q_re[j+1]),
            .out_q_im (dv_q_im[j+1]),
            .out_pay  (dv_pay[j+1])
        );
    end

    // ---------------------------------------------------------------------
    // Output stage: apply the sign, saturate, and hold the result until the
    // downstream side takes the transfer.
    // ---------------------------------------------------------------------
    localparam logic [QW-1:0] NEG_LIM = QW'(1) << (W - 1);
    localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

    ote_ctl_t     fin_ctl;
    logic         fin_nneg, fin_ineg, fin_novf, fin_iovf;
    logic [W-1:0] er_next, ei_next;
    logic         out_valid_reg, out_last_reg, out_zero_reg;
    logic [W-1:0] out_re_reg, out_im_reg;

    function automatic logic [W-1:0] sat_out(input logic [QW-1:0] q,
                                             input logic neg, input logic ovf);
        logic [W-1:0] r;
        if (neg)
        begin
            if (ovf || (q >= NEG_LIM))
                r = NEG_LIM[W-1:0];
            else
                r = W'(-q);
        end
        else
        begin
            if (ovf || (q > POS_LIM))
                r = POS_LIM[W-1:0];
            else
                r = q[W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        fin_ctl  = dv_ctl[DIV_N];
        fin_nneg = dv_pay[DIV_N][0];
        fin_ineg = dv_pay[DIV_N][1];
        fin_novf = dv_pay[DIV_N][2];
        fin_iovf = dv_pay[DIV_N][3];
        er_next  = sat_out(dv_q_re[DIV_N], fin_nneg, fin_novf);
        ei_next  = sat_out(dv_q_im[DIV_N], fin_ineg, fin_iovf);
        // A zero channel estimate has no phase to remove: force a zero result.
        if (fin_ctl.zero)
        begin
            er_next = '0;
            ei_next = '0;
        end
    end

    assign adv = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= fin_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_re_reg   <= er_next;
            out_im_reg   <= ei_next;
            out_zero_reg <= fin_ctl.zero;
            out_last_reg <= fin_ctl.last;
        end
    end

    assign s_axis_tready   = adv;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = OUT_TW'({out_im_reg, out_re_reg});
    assign m_axis_tuser[0] = out_zero_reg;
    assign m_axis_tlast    = out_last_reg;

    // A flagged zero channel must come out as an all-zero sample.
    `OTE_ASSERT_IMPLY(a_zero_out, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "zero channel with nonzero data")
    // A valid item leaving the divider while the pipeline moves must reach the output.
    `OTE_ASSERT_NEXT(a_div_to_out, clk, rst_n, fin_ctl.valid && adv, m_axis_tvalid, "item lost between divider and output")
    // The input side is held off only while a result waits and is not taken.
    `OTE_ASSERT_IMPLY(a_ready_rule, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

endmodule
